/* rtl/cpd_pkg.sv */
package cpd_pkg;

	localparam int SettleW = 10;
	localparam int GapW    = 12;
	localparam int CountW  = 3;
	localparam int WordW   = 16;
	localparam int CfgW    = 12;

	localparam logic [SettleW-1:0] SETTLE_RST = 10'd30;
	localparam logic [GapW-1:0]    GAP_RST    = 12'd200;

	// register index codes
	typedef enum logic [0:0] {
		REG_SETTLE = 1'b0,
		REG_GAP    = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_SMALL   = 2'd0,
		KIND_MID     = 2'd1,
		KIND_LARGE   = 2'd2,
		KIND_INVALID = 2'd3
	} coin_kind_t;

	// decode event from the edge tracker to the tally
	typedef struct packed {
		logic              done;
		logic [CountW-1:0] count;
	} coin_evt_t;

	typedef struct packed {
		logic [WordW-1:0] credit;
		logic [WordW-1:0] small_tot;
		logic [WordW-1:0] mid_tot;
		logic [WordW-1:0] large_tot;
	} tally_t;

endpackage

/* rtl/cpd_edge.sv */
module cpd_edge (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         pin_level,
	input  logic [cpd_pkg::SettleW-1:0]  settle_ms,
	input  logic [cpd_pkg::GapW-1:0]     gap_ms,
	output cpd_pkg::coin_evt_t           evt
);
	import cpd_pkg::*;

	logic               last_q;
	logic               pend_q;
	logic [SettleW-1:0] settle_q;
	logic [GapW-1:0]    gap_q;
	logic [CountW-1:0]  count_q;

	logic               chg;
	logic               pend_mid;
	logic               count_ev;
	logic [SettleW-1:0] settle_n;
	logic [GapW-1:0]    gap_n;
	logic [CountW-1:0]  count_mid;

	always_comb begin
		chg      = pin_level != last_q;
		settle_n = chg ? '0 : ((&settle_q) ? settle_q : settle_q + 1'b1);
		pend_mid = chg | pend_q;
		count_ev = pend_mid && (settle_n > settle_ms);
		count_mid = (count_ev && !(&count_q)) ? count_q + 1'b1 : count_q;
		gap_n    = count_ev ? '0 : ((&gap_q) ? gap_q : gap_q + 1'b1);
		evt.done  = (gap_n > gap_ms) && (count_mid != '0);
		evt.count = count_mid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= 1'b0;
			pend_q   <= 1'b0;
			settle_q <= '0;
			gap_q    <= '0;
			count_q  <= '0;
		end else if (en) begin
			last_q   <= pin_level;
			pend_q   <= pend_mid & ~count_ev;
			settle_q <= settle_n;
			gap_q    <= gap_n;
			count_q  <= evt.done ? '0 : count_mid;
		end
	end

endmodule

/* rtl/cpd_tally.sv */
module cpd_tally (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  cpd_pkg::coin_evt_t  evt,
	output cpd_pkg::coin_kind_t kind,
	output cpd_pkg::tally_t     tally_n
);
	import cpd_pkg::*;

	tally_t         tally_q;
	logic [WordW:0] credit_sum;
	logic [3:0]     credit_inc;

	function automatic logic [WordW-1:0] sat_inc(input logic [WordW-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	always_comb begin
		tally_n    = tally_q;
		kind       = KIND_SMALL;
		credit_inc = 4'd0;
		if (evt.done) begin
			unique case (evt.count)
				3'd1: begin
					kind              = KIND_SMALL;
					credit_inc        = 4'd1;
					tally_n.small_tot = sat_inc(tally_q.small_tot);
				end
				3'd2: begin
					kind            = KIND_MID;
					credit_inc      = 4'd2;
					tally_n.mid_tot = sat_inc(tally_q.mid_tot);
				end
				3'd3: begin
					kind              = KIND_LARGE;
					credit_inc        = 4'd10;
					tally_n.large_tot = sat_inc(tally_q.large_tot);
				end
				default: kind = KIND_INVALID;
			endcase
		end
		credit_sum     = {1'b0, tally_q.credit} + {{(WordW-3){1'b0}}, credit_inc};
		tally_n.credit = credit_sum[WordW] ? {WordW{1'b1}} : credit_sum[WordW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q <= '0;
		end else if (en) begin
			tally_q <= tally_n;
		end
	end

endmodule

/* rtl/coin_pulse_decoder_top.sv */
// Channel   Dir  Beat fields (low bit first)
// s_axis    in   tdata: pin_level, zero fill to 8 bits
// m_axis    out  tuser: coin_done, coin_kind
//                tdata: credit_units, small_total, mid_total, large_total
// cfg       in   cfg_we / cfg_index / cfg_data, index 0 settle_ms, 1 gap_ms
//
// One beat per clock sustained while m_axis_tready stays high. An accepted
// beat is registered in the input stage (s1), then the timer/decode logic
// runs in one pass as it moves into the result register (s2).
// Reset: all timers, counts, credit and totals clear; settle_ms=30, gap_ms=200.
// Stalls: s2 holds while m_axis_tready is low; s1 still takes a beat if empty,
// so a full pipeline holds two beats before s_axis_tready drops.
module coin_pulse_decoder_top (
	input  logic                      clk,
	input  logic                      arst_n,
	// slave side
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [7:0]                s_axis_tdata,   // [0] pin_level
	// master side
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [63:0]               m_axis_tdata,   // [15:0] credit_units,
	                                                  // [31:16] small_total,
	                                                  // [47:32] mid_total,
	                                                  // [63:48] large_total
	output logic [2:0]                m_axis_tuser,   // [0] coin_done, [2:1] coin_kind
	// configuration
	input  logic                      cfg_we,
	input  cpd_pkg::reg_idx_t         cfg_index,
	input  logic [cpd_pkg::CfgW-1:0]  cfg_data
);
	import cpd_pkg::*;

	// config registers
	logic [SettleW-1:0] settle_ms_q;
	logic [GapW-1:0]    gap_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_ms_q <= SETTLE_RST;
			gap_ms_q    <= GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SETTLE: settle_ms_q <= cfg_data[SettleW-1:0];
				REG_GAP:    gap_ms_q    <= cfg_data[GapW-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	logic valid_s1;
	logic level_s1;
	logic adv;   // s1 moves into s2 this cycle

	assign adv           = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			level_s1 <= s_axis_tdata[0];
		end
	end

	// decode pass, state commits only when the beat advances
	coin_evt_t  evt;
	coin_kind_t kind;
	tally_t     tally_n;

	cpd_edge u_edge (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.pin_level (level_s1),
		.settle_ms (settle_ms_q),
		.gap_ms    (gap_ms_q),
		.evt       (evt)
	);

	cpd_tally u_tally (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.evt     (evt),
		.kind    (kind),
		.tally_n (tally_n)
	);

	// result register
	logic        valid_s2;
	logic [63:0] data_s2;
	logic [2:0]  user_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= {tally_n.large_tot, tally_n.mid_tot, tally_n.small_tot, tally_n.credit};
			user_s2 <= {kind, evt.done};
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;
	assign m_axis_tuser  = user_s2;

`ifndef SYNTHESIS
	// kind is zero on beats that carry no coin
	a_kind_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tuser[2:1] == KIND_SMALL))
		else $error("coin_kind set without coin_done");

	// a stalled input beat does not advance or vanish
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(level_s1)))
		else $error("input stage lost a stalled beat");

	// credit never decreases from one result to the next
	a_credit_mono: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> (tally_n.credit >= u_tally.tally_q.credit))
		else $error("credit went down");
`endif

endmodule

/* verif/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cpd_pkg::*;

	// one predicted output beat
	typedef struct packed {
		logic              done;
		coin_kind_t        kind;
		logic [WordW-1:0]  credit;
		logic [WordW-1:0]  five_tot;
		logic [WordW-1:0]  ten_tot;
		logic [WordW-1:0]  fifty_tot;
	} coin_report_t;

	localparam int HOLD_OFF_CYCLES = 48;   // long receiver stall
	localparam int STALL_LIMIT     = 1000; // cycles with no beat on either side
	localparam int PRINT_CAP       = 40;   // mismatch lines shown before going quiet

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata;    // [0] pin_level, [7:1] zero
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [63:0]       m_axis_tdata;    // credit, five-cent, ten-cent, fifty-cent totals
	logic [2:0]        m_axis_tuser;    // [0] coin_done, [2:1] coin_kind
	logic              cfg_we;
	reg_idx_t          cfg_index;
	logic [CfgW-1:0]   cfg_data;

	coin_report_t      expected_reports[$];
	int                mismatch_count = 0;
	int                sent_beats     = 0;
	int                hold_len       = 0;    // receiver stall request, counted down below
	bit                calm_link      = 1'b0; // no random idling on either side
	logic              pin_now        = 1'b0; // level of the last beat sent

	// decoder model state and its copy of the registers
	logic [SettleW-1:0] cfg_settle;
	logic [GapW-1:0]    cfg_gap;
	logic               dec_level;
	logic               dec_pending;
	logic [SettleW-1:0] dec_settle;
	logic [GapW-1:0]    dec_gap;
	logic [CountW-1:0]  dec_count;
	logic [WordW-1:0]   dec_credit;
	logic [WordW-1:0]   dec_tot[3];

	coin_pulse_decoder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [WordW-1:0] sat_word(input logic [WordW-1:0] a,
			input logic [4:0] b);
		logic [WordW:0] s;
		s = a + b;
		return s[WordW] ? '1 : s[WordW-1:0];
	endfunction

	// One millisecond tick: level tracking, settle timer, transition count,
	// gap timer, then decode when the line has been quiet long enough.
	task automatic advance_decoder(input logic lvl, output coin_report_t r);
		r.done = 1'b0;
		r.kind = KIND_SMALL;
		if (lvl != dec_level) begin
			dec_level   = lvl;
			dec_settle  = '0;
			dec_pending = 1'b1;
		end else if (dec_settle != '1) begin
			dec_settle++;
		end
		if (dec_pending && dec_settle > cfg_settle) begin
			if (dec_count != '1)
				dec_count++;
			dec_gap     = '0;
			dec_pending = 1'b0;
		end else if (dec_gap != '1) begin
			dec_gap++;
		end
		if (dec_gap > cfg_gap && dec_count != 0) begin
			r.done = 1'b1;
			case (dec_count)
				3'd1: begin
					r.kind     = KIND_SMALL;
					dec_credit = sat_word(dec_credit, 5'd1);
					dec_tot[0] = sat_word(dec_tot[0], 5'd1);
				end
				3'd2: begin
					r.kind     = KIND_MID;
					dec_credit = sat_word(dec_credit, 5'd2);
					dec_tot[1] = sat_word(dec_tot[1], 5'd1);
				end
				3'd3: begin
					r.kind     = KIND_LARGE;
					dec_credit = sat_word(dec_credit, 5'd10);
					dec_tot[2] = sat_word(dec_tot[2], 5'd1);
				end
				default: begin
					// four or more transitions: flagged, no credit
					r.kind = KIND_INVALID;
				end
			endcase
			dec_count = '0;
		end
		r.credit    = dec_credit;
		r.five_tot  = dec_tot[0];
		r.ten_tot   = dec_tot[1];
		r.fifty_tot = dec_tot[2];
	endtask

	task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
			input logic [WordW-1:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("%0t ns: %s got %0h want %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic compare_field(input string what, input logic [WordW-1:0] got,
			input logic [WordW-1:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Output side: every accepted beat against the oldest prediction.
	always @(posedge clk) begin : check_results
		coin_report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_reports.size() == 0) begin
				report_mismatch("beat with nothing pending", m_axis_tdata[15:0], '0);
			end else begin
				want = expected_reports.pop_front();
				compare_field("coin_done", 16'(m_axis_tuser[0]), 16'(want.done));
				compare_field("coin_kind", 16'(m_axis_tuser[2:1]), 16'(want.kind));
				compare_field("credit_units", m_axis_tdata[15:0], want.credit);
				compare_field("small_total", m_axis_tdata[31:16], want.five_tot);
				compare_field("mid_total", m_axis_tdata[47:32], want.ten_tot);
				compare_field("large_total", m_axis_tdata[63:48], want.fifty_tot);
			end
		end
	end

	// Receiver: random ready, a counted stall when asked, steady when calm.
	always @(posedge clk) begin
		if (hold_len > 0) begin
			m_axis_tready <= 1'b0;
			hold_len--;
		end else if (calm_link) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= 25);
		end
	end

	// Watchdog: too long with no beat moving on either side ends the run.
	always @(posedge clk) begin : watchdog
		int quiet_cycles;
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Send one pin-level beat; random idle cycles ahead of it unless calm.
	task automatic push_level(input logic lvl);
		coin_report_t r;
		if (!calm_link) begin
			while ($urandom_range(0, 99) < 25) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'b0, lvl};
		do
			@(posedge clk);
		while (!s_axis_tready);
		advance_decoder(lvl, r);
		expected_reports.push_back(r);
		pin_now = lvl;
		sent_beats++;
	endtask

	task automatic hold_level(input logic lvl, input int n);
		repeat (n) push_level(lvl);
	endtask

	// k transitions, each held for 'dwell' ticks, then 'quiet' more ticks
	task automatic send_coin(input int k, input int dwell, input int quiet);
		repeat (k) hold_level(!pin_now, dwell);
		hold_level(pin_now, quiet);
	endtask

	// Sender stops and waits until every predicted beat has come out.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
	endtask

	// Registers change only with the pipeline empty.
	task automatic set_timing(input logic [CfgW-1:0] settle_data,
			input logic [CfgW-1:0] gap_data);
		drain_results();
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SETTLE;
		cfg_data  <= settle_data;
		@(posedge clk);
		cfg_index <= REG_GAP;
		cfg_data  <= gap_data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_settle = settle_data[SettleW-1:0];
		cfg_gap    = gap_data;
	endtask

	// Reset values: a glitch shorter than the settle time is dropped, then a
	// single transition at 30/200 makes a five-cent coin.
	task automatic test_reset_values();
		hold_level(1'b0, 3);
		hold_level(1'b1, 3);
		hold_level(1'b0, 4);
		send_coin(1, 33, 205);
	endtask

	// Both registers zero: a transition counts one tick after the change and
	// the coin ends one tick after that.
	task automatic test_zero_registers();
		set_timing('0, '0);
		send_coin(1, 2, 2);
		send_coin(1, 1, 3);
		send_coin(2, 2, 2);
	endtask

	// Every coin kind, plus counts of four and above, with the counter
	// stopping at seven.
	task automatic test_coin_kinds();
		set_timing(12'd1, 12'd6);
		send_coin(1, 3, 8);
		send_coin(2, 3, 8);
		send_coin(3, 3, 8);
		send_coin(4, 3, 8);
		send_coin(9, 3, 8);
		// holding exactly settle_ms is one tick short; the level stays, so it counts in the quiet stretch
		send_coin(1, 2, 8);
	endtask

	// Registers at their tops: with settle_ms at 1023 no transition ever
	// counts, so nothing decodes. The upper settle bits are written as ones.
	task automatic test_timer_saturation();
		set_timing(12'hFFF, 12'd4095);
		send_coin(2, 6, 10);
	endtask

	// Receiver stalls while the sender keeps offering, so the input stalls.
	task automatic test_backpressure();
		set_timing(12'd0, 12'd3);
		calm_link = 1'b1;
		hold_len  = HOLD_OFF_CYCLES;
		send_coin(3, 2, 6);
		send_coin(2, 2, 6);
		send_coin(1, 2, 6);
		drain_results();
		calm_link = 1'b0;
	endtask

	// Mostly well-formed pulse trains with random shape, some broken trains
	// and random noise, over several random timer settings.
	task automatic test_random_traffic();
		int settle_v, gap_v, stop_at, k, dwell;
		for (int phase = 0; phase < 6; phase++) begin
			settle_v = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 24)
			                                      : $urandom_range(0, 6);
			gap_v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8)
			                                   : settle_v + $urandom_range(5, 30);
			set_timing({2'($urandom_range(0, 3)), 10'(settle_v)}, 12'(gap_v));
			calm_link = (phase == 2);   // one long stretch with no idling
			stop_at   = sent_beats + 60;
			while (sent_beats < stop_at) begin
				if ($urandom_range(0, 9) < 8) begin
					k = ($urandom_range(0, 6) == 0) ? $urandom_range(4, 9)
					                                : $urandom_range(1, 3);
					repeat (k) begin
						// now and then a transition that does not settle
						dwell = ($urandom_range(0, 7) == 0) ? $urandom_range(1, settle_v + 1)
						                                    : settle_v + 2 + $urandom_range(0, 2);
						hold_level(!pin_now, dwell);
					end
					hold_level(pin_now, gap_v + 2 + $urandom_range(0, 3));
				end else begin
					repeat ($urandom_range(1, 8))
						push_level(1'($urandom_range(0, 1)));
				end
				// sender pause mid-phase until everything has come back
				if (phase == 3 && sent_beats >= stop_at - 45 && sent_beats < stop_at - 15)
					drain_results();
			end
			calm_link = 1'b0;
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_SETTLE;
		cfg_data      = '0;
		cfg_settle    = SETTLE_RST;
		cfg_gap       = GAP_RST;
		dec_level     = 1'b0;
		dec_pending   = 1'b0;
		dec_settle    = '0;
		dec_gap       = '0;
		dec_count     = '0;
		dec_credit    = '0;
		dec_tot[0]    = '0;
		dec_tot[1]    = '0;
		dec_tot[2]    = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_zero_registers();
		test_coin_kinds();
		test_timer_saturation();
		test_backpressure();
		test_random_traffic();

		drain_results();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* coin_pulse_decoder_top.f */
rtl/cpd_pkg.sv
rtl/cpd_edge.sv
rtl/cpd_tally.sv
rtl/coin_pulse_decoder_top.sv
verif/tb.sv
